/* rtl/smbp_pkg.sv */
// Package: phase codes, roles, status codes and element tables for the SNMP BER parser.
package smbp_pkg;

    typedef enum logic [4:0] {
        PH_OUTER_TAG = 5'd0,  PH_OUTER_LEN = 5'd1,
        PH_VER_TAG   = 5'd2,  PH_VER_LEN   = 5'd3,
        PH_COMM_TAG  = 5'd4,  PH_COMM_LEN  = 5'd5,
        PH_PDU_TAG   = 5'd6,  PH_PDU_LEN   = 5'd7,
        PH_RID_TAG   = 5'd8,  PH_RID_LEN   = 5'd9,
        PH_EST_TAG   = 5'd10, PH_EST_LEN   = 5'd11,
        PH_EIX_TAG   = 5'd12, PH_EIX_LEN   = 5'd13,
        PH_VBL_TAG   = 5'd14, PH_VBL_LEN   = 5'd15,
        PH_VB_TAG    = 5'd16, PH_VB_LEN    = 5'd17,
        PH_OID_TAG   = 5'd18, PH_OID_LEN   = 5'd19,
        PH_VAL_TAG   = 5'd20, PH_VAL_LEN   = 5'd21,
        PH_B_VER     = 5'd22, PH_B_COMM    = 5'd23,
        PH_B_RID     = 5'd24, PH_B_EST     = 5'd25,
        PH_B_EIX     = 5'd26, PH_B_OID     = 5'd27,
        PH_B_VAL     = 5'd28, PH_TRAIL     = 5'd29,
        PH_ERR       = 5'd30
    } phase_t;

    typedef enum logic [3:0] {
        ROLE_TAG = 4'd0, ROLE_LEN = 4'd1, ROLE_VERSION = 4'd2, ROLE_COMMUNITY = 4'd3,
        ROLE_PDU_TYPE = 4'd4, ROLE_REQID = 4'd5, ROLE_ERRSTAT = 4'd6,
        ROLE_ERRINDEX = 4'd7, ROLE_OID = 4'd8, ROLE_VALUE_TYPE = 4'd9,
        ROLE_VALUE = 4'd10, ROLE_TRAILING = 4'd11, ROLE_DISCARDED = 4'd12
    } role_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_BAD_TAG = 3'd1, ST_BAD_LEN_FORM = 3'd2,
        ST_MISMATCH = 3'd3, ST_BAD_VER_LEN = 3'd4, ST_TRUNCATED = 3'd5
    } status_t;

    localparam logic [7:0] TAG_SEQ  = 8'h30;
    localparam logic [7:0] TAG_INT  = 8'h02;
    localparam logic [7:0] TAG_OCT  = 8'h04;
    localparam logic [7:0] TAG_OID  = 8'h06;
    localparam logic [7:0] LEN_LONG = 8'h80;
    localparam logic [7:0] LEN_MASK = 8'h7F;

    localparam logic [3:0] EL_OUTER = 4'd0, EL_VER = 4'd1, EL_COMM = 4'd2, EL_PDU = 4'd3,
                           EL_RID = 4'd4, EL_EST = 4'd5, EL_EIX = 4'd6, EL_VBL = 4'd7,
                           EL_VB = 4'd8, EL_OID = 4'd9, EL_VAL = 4'd10;

    // enclosing end index per element
    function automatic logic [1:0] encl_of(input logic [3:0] el);
        logic [1:0] r;
        case (el)
            EL_RID, EL_EST, EL_EIX, EL_VBL: r = 2'd1;
            EL_VB:                          r = 2'd2;
            EL_OID, EL_VAL:                 r = 2'd3;
            default:                        r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

/* rtl/smbp_parse.sv */
// Parser state machine: phase, positions, element ends and header registers.
module smbp_parse #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output smbp_pkg::role_t       role,
    output logic [15:0]           varbind_number,
    output smbp_pkg::status_t     status,
    output logic [7:0]            version,
    output logic [7:0]            pdu_tag,
    output logic [31:0]           req_id,
    output logic [7:0]            err_status,
    output logic [7:0]            err_index
);
    import smbp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] nend_reg [4];
    logic [31:0] nend_next [4];
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  left_reg, left_next;
    logic [31:0] fend_reg, fend_next;
    logic [7:0]  ver_reg, ver_next, pdu_reg, pdu_next, est_reg, est_next, eix_reg, eix_next;
    logic [31:0] rid_reg, rid_next;
    logic [15:0] vbc_reg, vbc_next;
    status_t     ferr_reg, ferr_next;
    logic        okn_reg, okn_next;

    logic [31:0] nxt, len, lend;
    logic [3:0]  el;
    logic        is_len, done;
    logic [6:0]  nlen;

    always_comb
    begin
        phase_next = phase_reg;
        for (int i = 0; i < 4; i++)
            nend_next[i] = nend_reg[i];
        acc_next  = acc_reg;
        left_next = left_reg;
        fend_next = fend_reg;
        ver_next  = ver_reg;
        pdu_next  = pdu_reg;
        rid_next  = rid_reg;
        est_next  = est_reg;
        eix_next  = eix_reg;
        vbc_next  = vbc_reg;
        ferr_next = ferr_reg;
        okn_next  = okn_reg;
        nxt       = sat_add(pos_reg, 32'd1);
        role      = ROLE_DISCARDED;
        el        = phase_reg[4:1];
        is_len    = phase_reg[0];
        done      = 1'b0;
        len       = '0;
        lend      = '0;
        nlen      = data_byte[6:0] & LEN_MASK[6:0];

        if (phase_reg < PH_B_VER) begin
            role = is_len ? ROLE_LEN : (el == EL_PDU ? ROLE_PDU_TYPE :
                   (el == EL_VAL ? ROLE_VALUE_TYPE : ROLE_TAG));
            if (el != EL_OUTER && pos_reg >= nend_reg[encl_of(el)]) begin
                if (ferr_next == ST_OK) ferr_next = ST_MISMATCH;
                phase_next = PH_ERR;
            end else if (!is_len) begin
                if (el != EL_PDU && el != EL_VAL &&
                    data_byte != ((el == EL_OUTER || el == EL_VBL || el == EL_VB) ? TAG_SEQ :
                                  (el == EL_COMM) ? TAG_OCT : (el == EL_OID) ? TAG_OID : TAG_INT))
                begin
                    if (ferr_next == ST_OK) ferr_next = ST_BAD_TAG;
                    phase_next = PH_ERR;
                end else begin
                    if (el == EL_PDU) pdu_next = data_byte;
                    if (el == EL_VB && vbc_reg != 16'hFFFF) vbc_next = vbc_reg + 16'd1;
                    phase_next = phase_t'(phase_reg + 5'd1);
                    left_next  = '0;
                    acc_next   = '0;
                end
            end else begin
                if (left_reg == 3'd0) begin
                    if ((data_byte & LEN_LONG) != 8'd0) begin
                        if (nlen == 7'd0 || 32'(nlen) > 32'(MAX_LENGTH_BYTES)) begin
                            if (ferr_next == ST_OK) ferr_next = ST_BAD_LEN_FORM;
                            phase_next = PH_ERR;
                        end else begin
                            left_next = nlen[2:0];
                            acc_next  = '0;
                        end
                    end else begin
                        acc_next = {24'd0, data_byte};
                        done     = 1'b1;
                    end
                end else begin
                    acc_next  = {acc_reg[23:0], data_byte};
                    left_next = left_reg - 3'd1;
                    done      = (left_reg == 3'd1);
                end
                if (done) begin
                    len  = acc_next;
                    lend = sat_add(nxt, len);
                    if (el == EL_OUTER) begin
                        nend_next[0] = lend;
                        okn_next     = 1'b1;
                        phase_next   = PH_VER_TAG;
                    end else if (lend > nend_reg[encl_of(el)]) begin
                        if (ferr_next == ST_OK) ferr_next = ST_MISMATCH;
                        phase_next = PH_ERR;
                    end else begin
                        case (el)
                            EL_VER:
                                if (len != 32'd1) begin
                                    if (ferr_next == ST_OK) ferr_next = ST_BAD_VER_LEN;
                                    phase_next = PH_ERR;
                                end else begin
                                    fend_next = lend; phase_next = PH_B_VER;
                                end
                            EL_COMM:
                                if (len == 0) phase_next = PH_PDU_TAG;
                                else begin fend_next = lend; phase_next = PH_B_COMM; end
                            EL_PDU: begin nend_next[1] = lend; phase_next = PH_RID_TAG; end
                            EL_RID: begin
                                rid_next = '0;
                                if (len == 0) phase_next = PH_EST_TAG;
                                else begin fend_next = lend; phase_next = PH_B_RID; end
                            end
                            EL_EST: begin
                                est_next = '0;
                                if (len == 0) phase_next = PH_EIX_TAG;
                                else begin fend_next = lend; phase_next = PH_B_EST; end
                            end
                            EL_EIX: begin
                                eix_next = '0;
                                if (len == 0) phase_next = PH_VBL_TAG;
                                else begin fend_next = lend; phase_next = PH_B_EIX; end
                            end
                            EL_VBL: begin
                                nend_next[2] = lend;
                                phase_next   = (len == 0) ? PH_TRAIL : PH_VB_TAG;
                            end
                            EL_VB: begin nend_next[3] = lend; phase_next = PH_OID_TAG; end
                            EL_OID:
                                if (len == 0) phase_next = PH_VAL_TAG;
                                else begin fend_next = lend; phase_next = PH_B_OID; end
                            default:
                                if (len == 0) begin
                                    // empty value closes the varbind here
                                    if (nxt != nend_reg[3]) begin
                                        if (ferr_next == ST_OK) ferr_next = ST_MISMATCH;
                                        phase_next = PH_ERR;
                                    end else if (nxt == nend_reg[2]) phase_next = PH_TRAIL;
                                    else phase_next = PH_VB_TAG;
                                end else begin
                                    fend_next = lend; phase_next = PH_B_VAL;
                                end
                        endcase
                    end
                end
            end
        end else if (phase_reg <= PH_B_VAL) begin
            case (phase_reg)
                PH_B_VER:  begin role = ROLE_VERSION; ver_next = data_byte; end
                PH_B_COMM: role = ROLE_COMMUNITY;
                PH_B_RID:  begin role = ROLE_REQID; rid_next = {rid_reg[23:0], data_byte}; end
                PH_B_EST:  begin role = ROLE_ERRSTAT; est_next = data_byte; end
                PH_B_EIX:  begin role = ROLE_ERRINDEX; eix_next = data_byte; end
                PH_B_OID:  role = ROLE_OID;
                default:   role = ROLE_VALUE;
            endcase
            if (nxt == fend_reg) begin
                case (phase_reg)
                    PH_B_VER:  phase_next = PH_COMM_TAG;
                    PH_B_COMM: phase_next = PH_PDU_TAG;
                    PH_B_RID:  phase_next = PH_EST_TAG;
                    PH_B_EST:  phase_next = PH_EIX_TAG;
                    PH_B_EIX:  phase_next = PH_VBL_TAG;
                    PH_B_OID:  phase_next = PH_VAL_TAG;
                    default:
                        if (nxt != nend_reg[3]) begin
                            if (ferr_next == ST_OK) ferr_next = ST_MISMATCH;
                            phase_next = PH_ERR;
                        end else if (nxt == nend_reg[2]) phase_next = PH_TRAIL;
                        else phase_next = PH_VB_TAG;
                endcase
            end
        end else if (phase_reg == PH_TRAIL) begin
            role = ROLE_TRAILING;
        end

        varbind_number = vbc_next;
        if (okn_next && nend_next[0] != nxt)  status = ST_MISMATCH;
        else if (ferr_next != ST_OK)          status = ferr_next;
        else if (phase_next == PH_TRAIL)      status = ST_OK;
        else                                  status = ST_TRUNCATED;
        version    = ver_next;
        pdu_tag    = pdu_next;
        req_id     = rid_next;
        err_status = est_next;
        err_index  = eix_next;
        pos_next   = nxt;

        if (last_byte) begin
            phase_next = PH_OUTER_TAG;
            pos_next   = '0;
            for (int i = 0; i < 4; i++)
                nend_next[i] = '0;
            acc_next  = '0;
            left_next = '0;
            fend_next = '0;
            vbc_next  = '0;
            ferr_next = ST_OK;
            okn_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_OUTER_TAG;
            pos_reg   <= '0;
            for (int i = 0; i < 4; i++)
                nend_reg[i] <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
            fend_reg  <= '0;
            ver_reg   <= 8'd1;
            pdu_reg   <= 8'd160;
            rid_reg   <= '0;
            est_reg   <= '0;
            eix_reg   <= '0;
            vbc_reg   <= '0;
            ferr_reg  <= ST_OK;
            okn_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            for (int i = 0; i < 4; i++)
                nend_reg[i] <= nend_next[i];
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            fend_reg  <= fend_next;
            ver_reg   <= ver_next;
            pdu_reg   <= pdu_next;
            rid_reg   <= rid_next;
            est_reg   <= est_next;
            eix_reg   <= eix_next;
            vbc_reg   <= vbc_next;
            ferr_reg  <= ferr_next;
            okn_reg   <= okn_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> phase_reg == PH_OUTER_TAG && pos_reg == 32'd0)
        else $error("parser not restarted after last item");
    assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= 3'(MAX_LENGTH_BYTES))
        else $error("length byte count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        ferr_reg != ST_OK |-> phase_reg == PH_ERR)
        else $error("error recorded without entering discard phase");

endmodule

/* rtl/snmp_message_ber_parser_core.sv */
// Top level of the SNMP BER message parser: combinational parse step and a result register.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one byte per cycle while in_ready is high; a full, unread result register stalls input.
// in_ready stays high while the result register is empty or being taken this cycle.
// Reset (rst_n low, asynchronous) returns the parser to the outer sequence tag,
// sets version to 1, PDU type to 160 and clears the other header fields and counters.
module snmp_message_ber_parser_core #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  byte_out,
    output logic [3:0]  role,
    output logic [15:0] varbind_number,
    output logic        message_done,
    output logic [2:0]  status,
    output logic [7:0]  version,
    output logic [7:0]  pdu_tag,
    output logic [31:0] req_id,
    output logic [7:0]  err_status,
    output logic [7:0]  err_index
);
    import smbp_pkg::*;

    logic        step;
    role_t       p_role;
    status_t     p_status;
    logic [15:0] p_vbn;
    logic [7:0]  p_ver, p_pdu, p_est, p_eix;
    logic [31:0] p_rid;
    logic        ov_reg;

    assign in_ready  = !ov_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = ov_reg;

    smbp_parse #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_parse (
        .clk(clk), .rst_n(rst_n), .step(step),
        .data_byte(data_byte), .last_byte(last_byte),
        .role(p_role), .varbind_number(p_vbn), .status(p_status),
        .version(p_ver), .pdu_tag(p_pdu), .req_id(p_rid),
        .err_status(p_est), .err_index(p_eix)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (in_ready)
            ov_reg <= in_valid;
    end

    // header fields read as zero except on the last item of a message
    always_ff @(posedge clk)
    begin
        if (step) begin
            byte_out       <= data_byte;
            role           <= p_role;
            varbind_number <= p_vbn;
            message_done   <= last_byte;
            status         <= last_byte ? p_status : ST_OK;
            version        <= last_byte ? p_ver : 8'd0;
            pdu_tag        <= last_byte ? p_pdu : 8'd0;
            req_id         <= last_byte ? p_rid : 32'd0;
            err_status     <= last_byte ? p_est : 8'd0;
            err_index      <= last_byte ? p_eix : 8'd0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_out))
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("accepted item produced no result");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !message_done |-> status == ST_OK && req_id == 32'd0)
        else $error("header fields on a non-final result");

endmodule
